// ----- hw/rtl/doubly_linked_list_manager_assert.svh -----
// Assertion macros for the list manager.
`ifndef DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH
`define DOUBLY_LINKED_LIST_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS
`define DLLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLLM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DLLM_ASSERT(lbl, prop, msg)
`define DLLM_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/dllm_pkg.sv -----
package dllm_pkg;

  localparam int NODE_COUNT = 64;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int OP_W       = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OP_W-1:0]  op_t;

  localparam op_t OP_INIT      = 3'd0;
  localparam op_t OP_EMPTY     = 3'd1;
  localparam op_t OP_UNLINK    = 3'd2;
  localparam op_t OP_POP_HEAD  = 3'd3;
  localparam op_t OP_POP_TAIL  = 3'd4;
  localparam op_t OP_PUSH_TAIL = 3'd5;
  localparam op_t OP_PUSH_HEAD = 3'd6;

endpackage

// ----- hw/rtl/doubly_linked_list_manager.sv -----
// Channel | Ports                                         | Transaction
// in      | start, busy, in_opcode/head_index/entry_index  | start && !busy
// out     | out_strobe, out_returned_index, out_flag       | out_strobe, one cycle
//
// One transaction at a time; busy is high while it is worked on.
// Path from accept to result strobe: an unused opcode strobes from IDLE; init
// writes in W1; the empty test ends in RD1; unlink reads in RD1, writes in W1;
// pops read in RD1, RD2, write in W1; pushes write both memories in W1, W2.
// Reset (rst_n low, synchronous) clears control only; link contents are
// undefined until written. The receiver cannot stall; results are never held.
`include "doubly_linked_list_manager_assert.svh"

module doubly_linked_list_manager (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  dllm_pkg::op_t         in_opcode,
  input  dllm_pkg::idx_t        in_head_index,
  input  dllm_pkg::idx_t        in_entry_index,
  output logic                  out_strobe,
  output dllm_pkg::idx_t        out_returned_index,
  output logic                  out_flag
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_W1   = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  dllm_pkg::op_t  op_r, op_nxt;
  dllm_pkg::idx_t h_r, h_nxt, e_r, e_nxt;
  dllm_pkg::idx_t a_r, a_nxt, b_r, b_nxt, n_r, n_nxt;
  logic           strobe_r, strobe_nxt;
  dllm_pkg::idx_t ret_r, ret_nxt;
  logic           flag_r, flag_nxt;

  dllm_pkg::idx_t next_mem [dllm_pkg::NODE_COUNT];
  dllm_pkg::idx_t prev_mem [dllm_pkg::NODE_COUNT];
  dllm_pkg::idx_t next_q, prev_q;
  dllm_pkg::idx_t next_ra, prev_ra;
  logic           next_we, prev_we;
  dllm_pkg::idx_t next_wa, next_wd, prev_wa, prev_wd;

  logic accept;
  logic is_push;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign is_push = (op_r == dllm_pkg::OP_PUSH_TAIL) || (op_r == dllm_pkg::OP_PUSH_HEAD);

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_q <= prev_mem[prev_ra];
  end

  // read addresses: first reads at accept, chained reads from returned data
  always_comb begin
    if (state_r == S_RD1) begin
      next_ra = next_q;
      prev_ra = prev_q;
    end else if (in_opcode == dllm_pkg::OP_UNLINK) begin
      next_ra = in_entry_index;
      prev_ra = in_entry_index;
    end else begin
      next_ra = in_head_index;
      prev_ra = in_head_index;
    end
  end

  // link writes, in the order the list operations require
  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    next_wa = h_r;
    next_wd = h_r;
    prev_wa = h_r;
    prev_wd = h_r;
    if (state_r == S_W1) begin
      case (op_r)
        dllm_pkg::OP_INIT: begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
        dllm_pkg::OP_UNLINK: begin
          next_we = 1'b1; next_wa = b_r; next_wd = a_r;
          prev_we = 1'b1; prev_wa = a_r; prev_wd = b_r;
        end
        dllm_pkg::OP_POP_HEAD: begin
          next_we = 1'b1; next_wa = h_r; next_wd = a_r;
          prev_we = 1'b1; prev_wa = a_r; prev_wd = h_r;
        end
        dllm_pkg::OP_POP_TAIL: begin
          prev_we = 1'b1; prev_wa = h_r; prev_wd = b_r;
          next_we = 1'b1; next_wa = b_r; next_wd = h_r;
        end
        dllm_pkg::OP_PUSH_TAIL: begin
          next_we = 1'b1; next_wa = e_r; next_wd = h_r;
          prev_we = 1'b1; prev_wa = e_r; prev_wd = b_r;
        end
        dllm_pkg::OP_PUSH_HEAD: begin
          next_we = 1'b1; next_wa = e_r; next_wd = a_r;
          prev_we = 1'b1; prev_wa = e_r; prev_wd = h_r;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_W2) begin
      case (op_r)
        dllm_pkg::OP_PUSH_TAIL: begin
          next_we = 1'b1; next_wa = b_r; next_wd = e_r;
          prev_we = 1'b1; prev_wa = h_r; prev_wd = e_r;
        end
        dllm_pkg::OP_PUSH_HEAD: begin
          prev_we = 1'b1; prev_wa = a_r; prev_wd = e_r;
          next_we = 1'b1; next_wa = h_r; next_wd = e_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    h_nxt      = h_r;
    e_nxt      = e_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    n_nxt      = n_r;
    strobe_nxt = 1'b0;
    ret_nxt    = ret_r;
    flag_nxt   = flag_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_opcode;
          h_nxt  = in_head_index;
          e_nxt  = in_entry_index;
          case (in_opcode)
            dllm_pkg::OP_INIT: begin
              state_nxt = S_W1;
            end
            dllm_pkg::OP_EMPTY, dllm_pkg::OP_UNLINK, dllm_pkg::OP_POP_HEAD,
            dllm_pkg::OP_POP_TAIL, dllm_pkg::OP_PUSH_TAIL, dllm_pkg::OP_PUSH_HEAD: begin
              state_nxt = S_RD1;
            end
            default: begin
              strobe_nxt = 1'b1;
              ret_nxt    = '0;
              flag_nxt   = 1'b0;
            end
          endcase
        end
      end
      S_RD1: begin
        a_nxt = next_q;
        b_nxt = prev_q;
        n_nxt = (op_r == dllm_pkg::OP_POP_HEAD) ? next_q : prev_q;
        case (op_r)
          dllm_pkg::OP_EMPTY: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
            ret_nxt    = '0;
            flag_nxt   = (next_q == h_r);
          end
          dllm_pkg::OP_POP_HEAD, dllm_pkg::OP_POP_TAIL: begin
            state_nxt = S_RD2;
          end
          default: begin
            state_nxt = S_W1;
          end
        endcase
      end
      S_RD2: begin
        if (op_r == dllm_pkg::OP_POP_HEAD) begin
          a_nxt = next_q;
        end else begin
          b_nxt = prev_q;
        end
        state_nxt = S_W1;
      end
      S_W1: begin
        if (is_push) begin
          state_nxt = S_W2;
        end else begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          ret_nxt    = ((op_r == dllm_pkg::OP_POP_HEAD) || (op_r == dllm_pkg::OP_POP_TAIL))
                       ? n_r : '0;
          flag_nxt   = (op_r == dllm_pkg::OP_UNLINK) && (a_r == b_r);
        end
      end
      S_W2: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        ret_nxt    = '0;
        flag_nxt   = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r  <= op_nxt;
    h_r   <= h_nxt;
    e_r   <= e_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    ret_r <= ret_nxt;
    flag_r <= flag_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_returned_index = ret_r;
  assign out_flag           = flag_r;

  `DLLM_ASSERT(a_accept_progress, rst_n && accept |=> busy || out_strobe, "accepted transaction lost")
  `DLLM_NEVER(a_idle_no_write, (state_r == S_IDLE) && (next_we || prev_we), "link write while idle")
  `DLLM_ASSERT(a_w2_push_only, state_r == S_W2 |-> is_push, "second write phase outside push")
  `DLLM_ASSERT(a_rd2_pop_only, state_r == S_RD2 |-> (op_r == dllm_pkg::OP_POP_HEAD) || (op_r == dllm_pkg::OP_POP_TAIL), "chained read outside pop")
  `DLLM_NEVER(a_strobe_busy, out_strobe && (state_r != S_IDLE) && ($past(state_r) != S_IDLE), "result while still working")

endmodule
